>>> design/gfla_pkg.sv
// ----------------------------------------------------------------------------
// gfla_pkg
// Shared types and constants for the group free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package gfla_pkg;

  // Widths of the request and response fields.
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned TOTAL_W = 11;
  localparam int unsigned DEL_W   = 32;

  // Number of index fields carried by a request or a response.
  localparam int unsigned NUM_IDX = 4;

  // Default pool configuration.
  localparam int unsigned POOL_DEPTH_DEF = 1024;
  localparam int unsigned GROUP_SIZE_DEF = 4;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EXHAUSTED = 2'd1,
    STATUS_BAD_FREE  = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e             cmd;
    logic [IDX_W-1:0] free_index_0;
    logic [IDX_W-1:0] free_index_1;
    logic [IDX_W-1:0] free_index_2;
    logic [IDX_W-1:0] free_index_3;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [IDX_W-1:0]   got_index_0;
    logic [IDX_W-1:0]   got_index_1;
    logic [IDX_W-1:0]   got_index_2;
    logic [IDX_W-1:0]   got_index_3;
    logic [TOTAL_W-1:0] allocated_total;
    logic [TOTAL_W-1:0] high_water;
    logic [DEL_W-1:0]   deleted_total;
  } rsp_t;

endpackage

`default_nettype wire

>>> design/gfla_req_if.sv
// ----------------------------------------------------------------------------
// gfla_req_if
// Valid/ready channel that carries allocate and free requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfla_req_if
  import gfla_pkg::*;
();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/gfla_rsp_if.sv
// ----------------------------------------------------------------------------
// gfla_rsp_if
// Valid/ready channel that carries allocator responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface gfla_rsp_if
  import gfla_pkg::*;
();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

>>> design/group_free_list_allocator.sv
// ----------------------------------------------------------------------------
// group_free_list_allocator
// Allocates and frees groups of node indices from a fixed pool using a free
// stack backed by a single-port memory and a bump pointer.
// ----------------------------------------------------------------------------
// A request is taken only while the sequencer is idle. An allocate served from
// the free stack pops one index per cycle in ST_POP, waits in ST_POP_LAST for
// the last read to land and loads its response in ST_DONE; an allocate from the
// bump pointer steps through ST_BUMP and a free pushes through ST_PUSH, and
// each then loads its response in ST_DONE; an exhausted allocate or a rejected
// free goes from idle straight to ST_DONE to load it. After loading, the
// sequencer returns to idle before it can take the next request. The pace of
// the sequencer is set by the stack
// memory's single port, which moves one index per cycle, and by the one
// shared increment/decrement unit that steps the stack count or the bump
// pointer. A finished response waits in an output register, so the next
// request can be accepted while it is still pending; the sequencer stalls only
// when it has another response to load before the pending one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module group_free_list_allocator
  import gfla_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = POOL_DEPTH_DEF,
  parameter int unsigned GROUP_SIZE = GROUP_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gfla_req_if.sink    req_i,
  gfla_rsp_if.source  rsp_o
);

  localparam int unsigned CntW  = $clog2(POOL_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(POOL_DEPTH);
  localparam int unsigned KW    = $clog2(GROUP_SIZE + 1);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_POP      = 6'b000010,
    ST_POP_LAST = 6'b000100,
    ST_BUMP     = 6'b001000,
    ST_PUSH     = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [CntW-1:0]  fc_q, fc_d;
  logic [CntW-1:0]  bump_q, bump_d;
  logic [CntW-1:0]  peak_q, peak_d;
  logic [DEL_W-1:0] freed_q, freed_d;
  logic [KW-1:0]    k_q, k_d;
  logic             cap_vld_q, cap_vld_d;
  logic [KW-1:0]    cap_slot_q, cap_slot_d;
  status_e          status_q, status_d;
  logic [IDX_W-1:0] got_q [NUM_IDX];
  logic [IDX_W-1:0] got_d [NUM_IDX];
  logic [IDX_W-1:0] idx_q [NUM_IDX];
  logic [IDX_W-1:0] idx_d [NUM_IDX];
  logic             out_valid_q, out_valid_d;
  rsp_t             rsp_q, rsp_d;

  logic             req_fire;
  logic             rsp_load;
  logic [CntW-1:0]  unit_a;
  logic [CntW-1:0]  unit_res;
  logic             unit_dec;
  logic [CntW-1:0]  peak_new;

  logic             mem_we;
  logic             mem_re;
  logic [AddrW-1:0] mem_addr;
  logic [IDX_W-1:0] mem_wdata;
  logic [IDX_W-1:0] mem_rdata;

  gfla_stack_ram #(
    .DEPTH  (POOL_DEPTH),
    .DATA_W (IDX_W)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = rsp_q;

  // Shared counter unit: steps the bump pointer while bumping, otherwise the
  // stack count (down on a pop, up on a push).
  assign unit_a   = (state_q == ST_BUMP) ? bump_q : fc_q;
  assign unit_dec = (state_q == ST_POP);
  assign unit_res = unit_dec ? (unit_a - CntW'(1)) : (unit_a + CntW'(1));

  assign peak_new = (bump_q > peak_q) ? bump_q : peak_q;
  assign rsp_load = (state_q == ST_DONE) && (!out_valid_q || rsp_o.ready);

  always_comb begin
    state_d    = state_q;
    fc_d       = fc_q;
    bump_d     = bump_q;
    peak_d     = peak_q;
    freed_d    = freed_q;
    k_d        = k_q;
    cap_vld_d  = 1'b0;
    cap_slot_d = cap_slot_q;
    status_d   = status_q;
    got_d      = got_q;
    idx_d      = idx_q;
    rsp_d      = rsp_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_addr   = fc_q[AddrW-1:0];
    mem_wdata  = '0;

    if (out_valid_q && rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end

    // Land a popped index in the cycle after its read was issued.
    for (int j = 0; j < NUM_IDX; j++) begin
      if (cap_vld_q && int'(cap_slot_q) == j) begin
        got_d[j] = mem_rdata;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          idx_d[0] = req_i.payload.free_index_0;
          idx_d[1] = req_i.payload.free_index_1;
          idx_d[2] = req_i.payload.free_index_2;
          idx_d[3] = req_i.payload.free_index_3;
          for (int j = 0; j < NUM_IDX; j++) begin
            got_d[j] = '0;
          end
          status_d = STATUS_OK;
          if (req_i.payload.cmd == CMD_ALLOC) begin
            if (fc_q >= CntW'(GROUP_SIZE)) begin
              k_d     = '0;
              state_d = ST_POP;
            end else if (({1'b0, bump_q} + (CntW + 1)'(GROUP_SIZE))
                         <= (CntW + 1)'(POOL_DEPTH)) begin
              k_d     = '0;
              state_d = ST_BUMP;
            end else begin
              status_d = STATUS_EXHAUSTED;
              state_d  = ST_DONE;
            end
          end else begin
            if (bump_q == '0 || (({1'b0, fc_q} + (CntW + 1)'(GROUP_SIZE))
                                 > (CntW + 1)'(POOL_DEPTH))) begin
              status_d = STATUS_BAD_FREE;
              state_d  = ST_DONE;
            end else begin
              freed_d = freed_q + DEL_W'(GROUP_SIZE);
              k_d     = KW'(GROUP_SIZE);
              state_d = ST_PUSH;
            end
          end
        end
      end

      ST_POP: begin
        mem_re     = 1'b1;
        mem_addr   = unit_res[AddrW-1:0];
        fc_d       = unit_res;
        cap_vld_d  = 1'b1;
        cap_slot_d = k_q;
        if (k_q == KW'(GROUP_SIZE - 1)) begin
          state_d = ST_POP_LAST;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      ST_POP_LAST: begin
        state_d = ST_DONE;
      end

      ST_BUMP: begin
        for (int j = 0; j < NUM_IDX; j++) begin
          if (int'(k_q) == j) begin
            got_d[j] = IDX_W'(bump_q);
          end
        end
        bump_d = unit_res;
        if (k_q == KW'(GROUP_SIZE - 1)) begin
          state_d = ST_DONE;
        end else begin
          k_d = k_q + KW'(1);
        end
      end

      ST_PUSH: begin
        // Push the group last member first; members past the fourth are zero.
        mem_we = 1'b1;
        for (int j = 0; j < NUM_IDX; j++) begin
          if (int'(k_q) == j + 1) begin
            mem_wdata = idx_q[j];
          end
        end
        fc_d = unit_res;
        k_d  = k_q - KW'(1);
        if (k_q == KW'(1)) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (rsp_load) begin
          peak_d                = peak_new;
          rsp_d.status          = status_q;
          rsp_d.got_index_0     = got_q[0];
          rsp_d.got_index_1     = got_q[1];
          rsp_d.got_index_2     = got_q[2];
          rsp_d.got_index_3     = got_q[3];
          rsp_d.allocated_total = TOTAL_W'(bump_q);
          rsp_d.high_water      = TOTAL_W'(peak_new);
          rsp_d.deleted_total   = freed_q;
          out_valid_d           = 1'b1;
          state_d               = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      fc_q        <= '0;
      bump_q      <= '0;
      peak_q      <= '0;
      freed_q     <= '0;
      k_q         <= '0;
      cap_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fc_q        <= fc_d;
      bump_q      <= bump_d;
      peak_q      <= peak_d;
      freed_q     <= freed_d;
      k_q         <= k_d;
      cap_vld_q   <= cap_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_slot_q <= cap_slot_d;
    status_q   <= status_d;
    got_q      <= got_d;
    idx_q      <= idx_d;
    rsp_q      <= rsp_d;
  end

endmodule

`default_nettype wire

>>> design/gfla_stack_ram.sv
// ----------------------------------------------------------------------------
// gfla_stack_ram
// Single-port storage for the free stack, one access per cycle, registered
// read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gfla_stack_ram #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 10,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic              re_i,
  input  logic [AddrW-1:0]  addr_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire
